[rtl/dsps_pkg.sv]
// Shared definitions for the damped-sine pulse sequencer: field widths,
// command and register codes, reset values and the quarter-wave sine builder.
// No dependencies.
`timescale 1ns / 1ps

package dsps_pkg;

    // Parameter defaults
    localparam int MAX_PULSES_DEF = 16;
    localparam int SINE_BITS_DEF  = 10;
    localparam int COUNT_BITS_DEF = 24;

    // Fixed field widths
    localparam int CMD_W       = 2;
    localparam int IDX_IN_W    = 4;
    localparam int PHASE_W     = 32;
    localparam int DECAY_W     = 15;
    localparam int LEN_IN_W    = 24;
    localparam int SAMPLE_W    = 16;
    localparam int MAG_W       = 15;
    localparam int ENV_W       = 16;
    localparam int AMP_W       = 15;
    localparam int ENT_CNT_W   = 5;
    localparam int CFG_LEN_W   = 24;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 24;

    typedef logic [CMD_W-1:0]     t_cmd;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_cmd CMD_TICK    = 2'd0;
    localparam t_cmd CMD_LOAD    = 2'd1;
    localparam t_cmd CMD_RESTART = 2'd2;

    localparam t_cfg_idx REG_AMPLITUDE   = 2'd0;
    localparam t_cfg_idx REG_ENTRY_COUNT = 2'd1;
    localparam t_cfg_idx REG_INITIAL_GAP = 2'd2;
    localparam t_cfg_idx REG_FRAME_LIMIT = 2'd3;

    localparam logic [AMP_W-1:0]     AMP_RESET         = 15'd22937;
    localparam logic [ENT_CNT_W-1:0] ENTRY_COUNT_RESET = 5'd12;
    localparam logic [CFG_LEN_W-1:0] INITIAL_GAP_RESET = 24'd14400;
    localparam logic [CFG_LEN_W-1:0] FRAME_LIMIT_RESET = 24'd768000;
    localparam logic [ENV_W-1:0]     ENV_ONE           = 16'h8000;

    localparam longint unsigned Q30_ONE = 64'd1 << 30;

    // Quarter-wave sine sample k of a 2^bits table, Q15, by a nested
    // Taylor series in Q30. Only ever evaluated on constants.
    function automatic logic [MAG_W-1:0] quarter_sine(input int unsigned k,
                                                      input int unsigned bits);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned t;
        longint unsigned s;
        longint unsigned v;
        x  = (64'(k) * 64'd6746518852) >> bits;
        x2 = (x * x) >> 30;
        t  = Q30_ONE;
        t  = Q30_ONE - ((x2 * t) >> 30) / 64'd110;
        t  = Q30_ONE - ((x2 * t) >> 30) / 64'd72;
        t  = Q30_ONE - ((x2 * t) >> 30) / 64'd42;
        t  = Q30_ONE - ((x2 * t) >> 30) / 64'd20;
        t  = Q30_ONE - ((x2 * t) >> 30) / 64'd6;
        s  = (x * t) >> 30;
        v  = (s + 64'd16384) >> 15;
        if (v > 64'd32767) begin
            v = 64'd32767;
        end
        return v[MAG_W-1:0];
    endfunction

endpackage

[rtl/dsps_pulse_mem.sv]
// Pulse table storage: one synchronous RAM, one write and one read port,
// registered read data. No dependencies.
`timescale 1ns / 1ps

module dsps_pulse_mem #(
    parameter int  DEPTH  = 16,
    parameter int  WIDTH  = 95,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/dsps_sine_rom.sv]
// Sine magnitude lookup: quadrant fold onto a constant quarter-wave table,
// registered output. Depends on dsps_pkg.
`timescale 1ns / 1ps

module dsps_sine_rom #(
    parameter int SINE_BITS = dsps_pkg::SINE_BITS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_en,
    input  logic [SINE_BITS-1:0]       i_idx,
    output logic [dsps_pkg::MAG_W-1:0] o_mag,
    output logic                       o_neg
);

    localparam int K_W     = SINE_BITS - 1;
    localparam int QUARTER = 1 << (SINE_BITS - 2);

    logic [dsps_pkg::MAG_W-1:0] w_rom [QUARTER+1];
    logic [1:0]                 w_quad;
    logic [K_W-1:0]             w_k;
    logic [K_W-1:0]             w_k_fold;
    logic [dsps_pkg::MAG_W-1:0] r_mag;
    logic                       r_neg;

    for (genvar g = 0; g <= QUARTER; g++) begin : g_rom
        assign w_rom[g] = dsps_pkg::quarter_sine(g, SINE_BITS);
    end

    assign w_quad   = i_idx[SINE_BITS-1 -: 2];
    assign w_k      = {1'b0, i_idx[SINE_BITS-3:0]};
    // mirror the falling quadrants
    assign w_k_fold = w_quad[0] ? (K_W'(QUARTER) - w_k) : w_k;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_mag <= w_rom[w_k_fold];
            r_neg <= w_quad[1];
        end
    end

    assign o_mag = r_mag;
    assign o_neg = r_neg;

endmodule

[rtl/damped_sine_pulse_sequencer.sv]
// Damped-sine pulse sequencer top level: request handling, playback state,
// envelope and sample arithmetic. Depends on dsps_pkg, dsps_pulse_mem and
// dsps_sine_rom.
`timescale 1ns / 1ps

// Channel   Direction  Handshake                  Payload
// config    in         i_cfg_we                   i_cfg_index, i_cfg_data
// request   in         i_in_valid / o_in_stall    i_cmd, i_entry_index, i_phase_step,
//                                                 i_decay_factor, i_pulse_length,
//                                                 i_gap_length
// result    out        o_out_valid / i_out_stall  o_sample, o_sounding, o_finished
//
// Load, restart and unknown requests give no result.
// A tick runs through table RAM and sine table read, then envelope and
// amplitude products, then the final sample product into the output register.
// The output register may hold a result while the next request is taken;
// a tick waits in its last step only while that register is full and stalled.
// Synchronous active-low reset; the pulse table is not cleared and is undefined until loaded.

module damped_sine_pulse_sequencer #(
    parameter int MAX_PULSES      = dsps_pkg::MAX_PULSES_DEF,
    parameter int SINE_TABLE_BITS = dsps_pkg::SINE_BITS_DEF,
    parameter int COUNT_BITS      = dsps_pkg::COUNT_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // configuration
    input  logic                                i_cfg_we,
    input  logic [dsps_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [dsps_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    // requests
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [dsps_pkg::CMD_W-1:0]          i_cmd,
    input  logic [dsps_pkg::IDX_IN_W-1:0]       i_entry_index,
    input  logic [dsps_pkg::PHASE_W-1:0]        i_phase_step,
    input  logic [dsps_pkg::DECAY_W-1:0]        i_decay_factor,
    input  logic [dsps_pkg::LEN_IN_W-1:0]       i_pulse_length,
    input  logic [dsps_pkg::LEN_IN_W-1:0]       i_gap_length,
    // results
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic signed [dsps_pkg::SAMPLE_W-1:0] o_sample,
    output logic                                o_sounding,
    output logic                                o_finished
);

    localparam int IDX_W   = (MAX_PULSES > 1) ? $clog2(MAX_PULSES) : 1;
    localparam int ENT_W   = $clog2(MAX_PULSES + 1);
    localparam int PH_W    = dsps_pkg::PHASE_W;
    localparam int DC_W    = dsps_pkg::DECAY_W;
    localparam int ENV_W   = dsps_pkg::ENV_W;
    localparam int MAG_W   = dsps_pkg::MAG_W;
    localparam int ENTRY_W = PH_W + DC_W + 2 * COUNT_BITS;
    // entry word layout: phase step | decay | pulse length | gap length
    localparam int GAP_LSB   = 0;
    localparam int PULSE_LSB = COUNT_BITS;
    localparam int DECAY_LSB = 2 * COUNT_BITS;
    localparam int PHASE_LSB = 2 * COUNT_BITS + DC_W;
    localparam int EP_W      = ENV_W + DC_W;          // envelope x decay
    localparam int AE_W      = dsps_pkg::AMP_W + ENV_W; // amplitude x envelope
    localparam int PR_W      = AE_W + MAG_W;          // full sample product
    localparam int SH        = 30;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_MUL1 = 2'd1;
    localparam logic [1:0] S_MUL2 = 2'd2;

    // configuration registers
    logic [dsps_pkg::AMP_W-1:0]     r_amplitude;
    logic [dsps_pkg::ENT_CNT_W-1:0] r_entry_count;
    logic [dsps_pkg::CFG_LEN_W-1:0] r_initial_gap;
    logic [dsps_pkg::CFG_LEN_W-1:0] r_frame_limit;

    // playback state
    logic [1:0]            r_state;
    logic [ENT_W-1:0]      r_cur,    n_cur;
    logic                  r_sil,    n_sil;
    logic [COUNT_BITS-1:0] r_frames, n_frames;
    logic [PH_W-1:0]       r_phase,  n_phase;
    logic [ENV_W-1:0]      r_env,    n_env;
    logic [COUNT_BITS-1:0] r_ticks,  n_ticks;
    logic                  r_ended,  n_ended;
    logic                  n_sounding;

    // tick datapath
    logic [AE_W-1:0]       r_amp_env;
    logic                  r_res_sounding;
    logic                  r_res_finished;

    // output register
    logic                                r_out_valid;
    logic signed [dsps_pkg::SAMPLE_W-1:0] r_out_sample;
    logic                                r_out_sounding;
    logic                                r_out_finished;

    logic                  w_accept;
    logic                  w_tick;
    logic                  w_load;
    logic                  w_restart;
    logic                  w_load_ok;
    logic [ENTRY_W-1:0]    w_wdata;
    logic [ENTRY_W-1:0]    w_rdata;
    logic [PH_W-1:0]       w_step;
    logic [DC_W-1:0]       w_decay;
    logic [COUNT_BITS-1:0] w_pulse_len;
    logic [COUNT_BITS-1:0] w_gap_len;
    logic [MAG_W-1:0]      w_mag;
    logic                  w_neg;
    logic [31:0]           w_limit;
    logic [EP_W-1:0]       w_env_prod;
    logic [AE_W-1:0]       w_amp_env;
    logic [PR_W-1:0]       w_prod;
    logic [dsps_pkg::SAMPLE_W-1:0] w_mag_out;
    logic [dsps_pkg::SAMPLE_W-1:0] w_sample;
    logic                  w_out_free;
    logic                  w_out_take;

    assign o_in_stall = (r_state != S_IDLE);
    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_tick     = w_accept && (i_cmd == dsps_pkg::CMD_TICK);
    assign w_load     = w_accept && (i_cmd == dsps_pkg::CMD_LOAD);
    assign w_restart  = w_accept && (i_cmd == dsps_pkg::CMD_RESTART);
    // drop loads aimed beyond the table
    assign w_load_ok  = w_load && (32'(i_entry_index) < 32'(MAX_PULSES));

    // ---------------------------------------------------------------
    // Configuration writes
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_amplitude   <= dsps_pkg::AMP_RESET;
            r_entry_count <= dsps_pkg::ENTRY_COUNT_RESET;
            r_initial_gap <= dsps_pkg::INITIAL_GAP_RESET;
            r_frame_limit <= dsps_pkg::FRAME_LIMIT_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                dsps_pkg::REG_AMPLITUDE:   r_amplitude   <= i_cfg_data[dsps_pkg::AMP_W-1:0];
                dsps_pkg::REG_ENTRY_COUNT: r_entry_count <= i_cfg_data[dsps_pkg::ENT_CNT_W-1:0];
                dsps_pkg::REG_INITIAL_GAP: r_initial_gap <= i_cfg_data[dsps_pkg::CFG_LEN_W-1:0];
                dsps_pkg::REG_FRAME_LIMIT: r_frame_limit <= i_cfg_data[dsps_pkg::CFG_LEN_W-1:0];
                default: ;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Pulse table: written by loads, read at the current entry on a tick.
    // Only one request is in flight, so a write never meets a read of the
    // same entry.
    // ---------------------------------------------------------------
    assign w_wdata = {i_phase_step, i_decay_factor,
                      COUNT_BITS'(i_pulse_length), COUNT_BITS'(i_gap_length)};

    dsps_pulse_mem #(
        .DEPTH (MAX_PULSES),
        .WIDTH (ENTRY_W)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (w_load_ok),
        .i_waddr (IDX_W'(i_entry_index)),
        .i_wdata (w_wdata),
        .i_re    (w_tick),
        .i_raddr (r_cur[IDX_W-1:0]),
        .o_rdata (w_rdata)
    );

    assign w_step      = w_rdata[PHASE_LSB +: PH_W];
    assign w_decay     = w_rdata[DECAY_LSB +: DC_W];
    assign w_pulse_len = w_rdata[PULSE_LSB +: COUNT_BITS];
    assign w_gap_len   = w_rdata[GAP_LSB +: COUNT_BITS];

    // sine of the phase before this tick's advance
    dsps_sine_rom #(
        .SINE_BITS (SINE_TABLE_BITS)
    ) u_sine (
        .i_clk (i_clk),
        .i_en  (w_tick),
        .i_idx (r_phase[PH_W-1 -: SINE_TABLE_BITS]),
        .o_mag (w_mag),
        .o_neg (w_neg)
    );

    // ---------------------------------------------------------------
    // Tick update, evaluated in S_MUL1 once the table entry is back
    // ---------------------------------------------------------------
    assign w_limit    = (32'(r_entry_count) > 32'(MAX_PULSES)) ? 32'(MAX_PULSES)
                                                                : 32'(r_entry_count);
    assign w_env_prod = EP_W'(r_env) * EP_W'(w_decay);
    assign w_amp_env  = AE_W'(r_amplitude) * AE_W'(r_env);

    always_comb begin
        n_cur      = r_cur;
        n_sil      = r_sil;
        n_frames   = r_frames;
        n_phase    = r_phase;
        n_env      = r_env;
        n_ticks    = r_ticks;
        n_ended    = r_ended;
        n_sounding = 1'b0;
        if (r_ended || (32'(r_ticks) >= 32'(r_frame_limit))) begin
            n_ended = 1'b1;
        end else begin
            if (!(&r_ticks)) begin
                n_ticks = r_ticks + 1'b1;
            end
            if (r_sil) begin
                if (r_frames <= COUNT_BITS'(1)) begin
                    // gap over: start the next pulse or finish
                    if (32'(r_cur) >= w_limit) begin
                        n_ended = 1'b1;
                    end else begin
                        n_sil    = 1'b0;
                        n_phase  = '0;
                        n_env    = dsps_pkg::ENV_ONE;
                        n_frames = w_pulse_len;
                    end
                end else begin
                    n_frames = r_frames - 1'b1;
                end
            end else begin
                n_sounding = 1'b1;
                n_phase    = r_phase + w_step;
                n_env      = w_env_prod[DC_W +: ENV_W];
                if (r_frames <= COUNT_BITS'(1)) begin
                    n_sil    = 1'b1;
                    n_frames = w_gap_len;
                    n_cur    = r_cur + 1'b1;
                end else begin
                    n_frames = r_frames - 1'b1;
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Sample: amplitude x envelope x |sine| >> 30, sign restored
    // ---------------------------------------------------------------
    assign w_prod     = PR_W'(r_amp_env) * PR_W'(w_mag);
    assign w_mag_out  = w_prod[SH +: dsps_pkg::SAMPLE_W];
    assign w_sample   = !r_res_sounding ? '0 : (w_neg ? (-w_mag_out) : w_mag_out);
    assign w_out_take = r_out_valid && !i_out_stall;
    assign w_out_free = !r_out_valid || !i_out_stall;

    // ---------------------------------------------------------------
    // Sequencer and playback registers
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cur    <= '0;
            r_sil    <= 1'b1;
            r_frames <= COUNT_BITS'(dsps_pkg::INITIAL_GAP_RESET);
            r_phase  <= '0;
            r_env    <= dsps_pkg::ENV_ONE;
            r_ticks  <= '0;
            r_ended  <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (w_tick) begin
                        r_state <= S_MUL1;
                    end else if (w_restart) begin
                        // back to the start; registers and table kept
                        r_cur    <= '0;
                        r_sil    <= 1'b1;
                        r_frames <= COUNT_BITS'(r_initial_gap);
                        r_phase  <= '0;
                        r_env    <= dsps_pkg::ENV_ONE;
                        r_ticks  <= '0;
                        r_ended  <= 1'b0;
                    end
                end
                S_MUL1: begin
                    r_cur    <= n_cur;
                    r_sil    <= n_sil;
                    r_frames <= n_frames;
                    r_phase  <= n_phase;
                    r_env    <= n_env;
                    r_ticks  <= n_ticks;
                    r_ended  <= n_ended;
                    r_state  <= S_MUL2;
                end
                S_MUL2: begin
                    // hold until the output register can take the result
                    if (w_out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_MUL1) begin
            r_amp_env      <= w_amp_env;
            r_res_sounding <= n_sounding;
            r_res_finished <= n_ended;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == S_MUL2) && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (w_out_take) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_MUL2) && w_out_free) begin
            r_out_sample   <= w_sample;
            r_out_sounding <= r_res_sounding;
            r_out_finished <= r_res_finished;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_sample    = r_out_sample;
    assign o_sounding  = r_out_sounding;
    assign o_finished  = r_out_finished;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    a_env_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_env <= dsps_pkg::ENV_ONE)
        else $error("envelope above unity");

    a_entry_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_cur) <= 32'(MAX_PULSES))
        else $error("entry counter beyond table");

    a_pulse_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_sil |-> (32'(r_cur) < 32'(MAX_PULSES)))
        else $error("pulse playing from an entry outside the table");

    a_ended_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ended && !w_restart) |=> r_ended)
        else $error("playback left the finished state without restart");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |=> r_out_valid)
        else $error("pending result lost");

endmodule
